// ----- rtl/core/ubx_fp_pkg.sv -----
`default_nettype none

package ubx_fp_pkg;

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_SYNC1 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_ID    = 4'd3;
    localparam logic [3:0] PH_LENLO = 4'd4;
    localparam logic [3:0] PH_LENHI = 4'd5;
    localparam logic [3:0] PH_DATA  = 4'd6;
    localparam logic [3:0] PH_CKA   = 4'd7;
    localparam logic [3:0] PH_CKB   = 4'd8;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_GOOD = 3'd1;
    localparam logic [2:0] EV_SYNC = 3'd2;
    localparam logic [2:0] EV_LEN  = 3'd3;
    localparam logic [2:0] EV_CK   = 3'd4;
    localparam logic [2:0] EV_OVRN = 3'd5;

    localparam logic [1:0] REQ_RX   = 2'd0;
    localparam logic [1:0] REQ_REL  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [7:0] msg_length;
        logic [7:0] read_data;
        logic       msg_available;
        logic [7:0] overrun_count;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/ubx_frame_parser.sv -----
`default_nettype none
// one transaction per cycle while results are taken, bytes, releases and reads alike
// a result is held in the s1 register, then written to the result queue before it is valid
// parse and buffer read fill the s1 register; the result queue write follows
// payload buffer is a one-port-write, one-port-read memory with a registered read
// a two-entry result queue lets input continue while a result waits
// synchronous active-low reset clears parser state, flags and counts, restores sync values

module ubx_frame_parser
    import ubx_fp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_msg_class,
    output logic [7:0]       o_msg_id,
    output logic [7:0]       o_msg_length,
    output logic [7:0]       o_read_data,
    output logic             o_msg_available,
    output logic [7:0]       o_overrun_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    r_sync_first;
    logic [7:0]    r_sync_second;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          s1_valid;
    logic          s1_rd;
    t_result       s1;
    t_result       push_data;
    t_result       head;
    logic [1:0]    q_count;
    logic          pop;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SYNC_FIRST) begin
                r_sync_first <= pwdata[7:0];
            end else begin
                r_sync_second <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_SYNC_FIRST:  prdata = {24'd0, r_sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_sync_second};
            default:         prdata = 32'd0;
        endcase
    end

    // handshake
    assign pop        = o_out_valid && i_out_ready;
    assign o_in_ready = ((2'(s1_valid) + q_count) < 2'd2) || pop;
    assign accept     = i_in_valid && o_in_ready;

    ubx_fp_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .PW          (PW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_rx_byte     (i_rx_byte),
        .i_read_index  (i_read_index),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_s1_valid    (s1_valid),
        .o_s1_rd       (s1_rd),
        .o_s1          (s1)
    );

    ubx_fp_buf #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        push_data           = s1;
        push_data.read_data = s1_rd ? rd_data : 8'd0;
    end

    ubx_fp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s1_valid),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_count     (q_count)
    );

    assign o_out_valid     = (q_count != 2'd0);
    assign o_event_res     = head.event_res;
    assign o_msg_class     = head.msg_class;
    assign o_msg_id        = head.msg_id;
    assign o_msg_length    = head.msg_length;
    assign o_read_data     = head.read_data;
    assign o_msg_available = head.msg_available;
    assign o_overrun_count = head.overrun_count;

endmodule

`default_nettype wire

// ----- rtl/core/ubx_fp_buf.sv -----
`default_nettype none

module ubx_fp_buf
    import ubx_fp_pkg::*;
#(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/ubx_fp_ctrl.sv -----
`default_nettype none

module ubx_fp_ctrl
    import ubx_fp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255,
    parameter int AW          = 8,
    parameter int PW          = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [7:0]    i_read_index,
    input  wire logic [7:0]    i_sync_first,
    input  wire logic [7:0]    i_sync_second,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output logic               o_s1_valid,
    output logic               o_s1_rd,
    output t_result            o_s1
);

    logic [3:0]    r_phase, n_phase;
    logic [15:0]   r_frame_length, n_frame_length;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_sum_a, n_sum_a;
    logic [7:0]    r_sum_b, n_sum_b;
    logic [7:0]    r_class, n_class;
    logic [7:0]    r_id, n_id;
    logic          r_held, n_held;
    logic [7:0]    r_drop, n_drop;
    logic [2:0]    n_event;

    logic          r_s1_valid;
    logic          r_s1_rd;
    t_result       r_s1;

    logic [7:0]    sum_a_t;
    logic [7:0]    sum_b_t;
    logic [15:0]   len_t;
    logic [PW-1:0] pos_inc;
    logic [15:0]   idx_ext;

    assign sum_a_t = r_sum_a + i_rx_byte;
    assign sum_b_t = r_sum_b + sum_a_t;
    assign len_t   = {i_rx_byte, r_frame_length[7:0]};
    assign pos_inc = r_pos + PW'(1);
    assign idx_ext = {8'd0, i_read_index};

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_pos          = r_pos;
        n_sum_a        = r_sum_a;
        n_sum_b        = r_sum_b;
        n_class        = r_class;
        n_id           = r_id;
        n_held         = r_held;
        n_drop         = r_drop;
        n_event        = EV_NONE;
        o_wr_en        = 1'b0;
        o_rd_en        = 1'b0;
        if (i_accept) begin
            case (i_req_type)
                REQ_RX: begin
                    if (r_phase < PH_CKA) begin
                        n_sum_a = sum_a_t;
                        n_sum_b = sum_b_t;
                    end
                    case (r_phase)
                        PH_HUNT: begin
                            if (i_rx_byte == i_sync_first) begin
                                n_phase = PH_SYNC1;
                            end
                        end
                        PH_SYNC1: begin
                            if (i_rx_byte != i_sync_second) begin
                                n_event = EV_SYNC;
                                n_phase = PH_HUNT;
                            end else begin
                                n_sum_a = 8'd0;
                                n_sum_b = 8'd0;
                                n_phase = PH_CLASS;
                            end
                        end
                        PH_CLASS: begin
                            if (r_held) begin
                                n_drop  = r_drop + 8'd1;
                                n_event = EV_OVRN;
                                n_phase = PH_HUNT;
                            end else begin
                                n_class = i_rx_byte;
                                n_phase = PH_ID;
                            end
                        end
                        PH_ID: begin
                            n_id    = i_rx_byte;
                            n_phase = PH_LENLO;
                        end
                        PH_LENLO: begin
                            n_frame_length = {8'd0, i_rx_byte};
                            n_phase        = PH_LENHI;
                        end
                        PH_LENHI: begin
                            n_frame_length = len_t;
                            n_pos          = '0;
                            if (len_t > 16'(MAX_PAYLOAD)) begin
                                n_event = EV_LEN;
                                n_phase = PH_HUNT;
                            end else if (len_t == 16'd0) begin
                                n_phase = PH_CKA;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            o_wr_en = 1'b1;
                            n_pos   = pos_inc;
                            if (16'(pos_inc) >= r_frame_length) begin
                                n_phase = PH_CKA;
                            end
                        end
                        PH_CKA: begin
                            if (i_rx_byte != r_sum_a) begin
                                n_event = EV_CK;
                                n_phase = PH_HUNT;
                            end else begin
                                n_phase = PH_CKB;
                            end
                        end
                        PH_CKB: begin
                            if (i_rx_byte != r_sum_b) begin
                                n_event = EV_CK;
                            end else begin
                                n_held  = 1'b1;
                                n_event = EV_GOOD;
                            end
                            n_phase = PH_HUNT;
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
                REQ_REL: begin
                    n_held = 1'b0;
                end
                REQ_READ: begin
                    o_rd_en = (idx_ext < 16'(MAX_PAYLOAD));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_addr = r_pos[AW-1:0];
    assign o_wr_data = i_rx_byte;
    assign o_rd_addr = AW'(idx_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_frame_length <= '0;
            r_pos          <= '0;
            r_sum_a        <= '0;
            r_sum_b        <= '0;
            r_class        <= '0;
            r_id           <= '0;
            r_held         <= 1'b0;
            r_drop         <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_pos          <= n_pos;
            r_sum_a        <= n_sum_a;
            r_sum_b        <= n_sum_b;
            r_class        <= n_class;
            r_id           <= n_id;
            r_held         <= n_held;
            r_drop         <= n_drop;
            r_s1_valid     <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_rd             <= o_rd_en;
            r_s1.event_res      <= n_event;
            r_s1.msg_class      <= n_class;
            r_s1.msg_id         <= n_id;
            r_s1.msg_length     <= n_frame_length[7:0];
            r_s1.read_data      <= 8'd0;
            r_s1.msg_available  <= n_held;
            r_s1.overrun_count  <= n_drop;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_rd    = r_s1_rd;
    assign o_s1       = r_s1;

`ifndef SYNTHESIS
    a_good_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.event_res == EV_GOOD) |-> r_s1.msg_available)
        else $error("good frame without held message");

    a_drop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && n_event == EV_OVRN) |=> (r_drop == $past(r_drop) + 8'd1))
        else $error("overrun drop not counted");

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("buffer written and read by one transaction");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ubx_fp_outq.sv -----
`default_nettype none

module ubx_fp_outq
    import ubx_fp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_push_data,
    input  wire logic     i_pop,
    output t_result       o_head,
    output logic [1:0]    o_count
);

    t_result    r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_entry[r_rd_ptr];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < 2'd2))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("result queue underflow");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_ubx_frame_parser.sv -----
module tb_ubx_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ubx_fp_pkg::*;

    localparam int PAYLOAD_MAX = 255;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum {
        FR_GOOD, FR_BAD_SYNC, FR_BAD_LEN, FR_BAD_CKA, FR_BAD_CKB, FR_CUT
    } t_frame_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = REQ_RX;
    logic [7:0]  i_rx_byte = '0;
    logic [7:0]  i_read_index = '0;
    logic        i_out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    wire logic        o_in_ready;
    wire logic        o_out_valid;
    wire logic [2:0]  o_event_res;
    wire logic [7:0]  o_msg_class;
    wire logic [7:0]  o_msg_id;
    wire logic [7:0]  o_msg_length;
    wire logic [7:0]  o_read_data;
    wire logic        o_msg_available;
    wire logic [7:0]  o_overrun_count;
    wire logic [31:0] prdata;
    wire logic        pready;

    // parser state as predicted
    logic [7:0]  cfg_sync_first = SYNC_FIRST_RST;
    logic [7:0]  cfg_sync_second = SYNC_SECOND_RST;
    logic [3:0]  parse_ph = PH_HUNT;
    logic [15:0] frame_len = '0;
    logic [15:0] pay_pos = '0;
    logic [7:0]  run_sum_a = '0;
    logic [7:0]  run_sum_b = '0;
    logic [7:0]  class_q = '0;
    logic [7:0]  id_q = '0;
    logic        msg_held = 1'b0;
    logic [7:0]  drop_cnt = '0;
    logic [7:0]  pay_mem [PAYLOAD_MAX];
    bit          pay_written [PAYLOAD_MAX];
    int          written_cnt = 0;

    t_result pending_results[$];
    int      errors = 0;
    int      items_sent = 0;
    int      in_idle_pct = 13;
    int      out_idle_pct = 54;
    bit      stall_req = 1'b0;
    int      stall_left = 0;

    ubx_frame_parser #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_rx_byte(i_rx_byte),
        .i_read_index(i_read_index),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_event_res(o_event_res),
        .o_msg_class(o_msg_class),
        .o_msg_id(o_msg_id),
        .o_msg_length(o_msg_length),
        .o_read_data(o_read_data),
        .o_msg_available(o_msg_available),
        .o_overrun_count(o_overrun_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [2:0] parse_byte(logic [7:0] c);
        logic [2:0] ev;
        ev = EV_NONE;
        if (parse_ph < PH_CKA) begin
            run_sum_a = run_sum_a + c;
            run_sum_b = run_sum_b + run_sum_a;
        end
        case (parse_ph)
            PH_HUNT: begin
                if (c == cfg_sync_first) parse_ph = PH_SYNC1;
            end
            PH_SYNC1: begin
                if (c != cfg_sync_second) begin
                    ev = EV_SYNC;
                    parse_ph = PH_HUNT;
                end else begin
                    run_sum_a = '0;
                    run_sum_b = '0;
                    parse_ph = PH_CLASS;
                end
            end
            PH_CLASS: begin
                if (msg_held) begin
                    drop_cnt = drop_cnt + 8'd1;
                    ev = EV_OVRN;
                    parse_ph = PH_HUNT;
                end else begin
                    class_q = c;
                    parse_ph = PH_ID;
                end
            end
            PH_ID: begin
                id_q = c;
                parse_ph = PH_LENLO;
            end
            PH_LENLO: begin
                frame_len = {8'h00, c};
                parse_ph = PH_LENHI;
            end
            PH_LENHI: begin
                frame_len[15:8] = c;
                pay_pos = '0;
                if (frame_len > 16'(PAYLOAD_MAX)) begin
                    ev = EV_LEN;
                    parse_ph = PH_HUNT;
                end else if (frame_len == 16'd0) begin
                    parse_ph = PH_CKA;
                end else begin
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA: begin
                if (pay_pos < 16'(PAYLOAD_MAX)) begin
                    pay_mem[pay_pos[7:0]] = c;
                    if (!pay_written[pay_pos[7:0]]) written_cnt++;
                    pay_written[pay_pos[7:0]] = 1'b1;
                end
                pay_pos = pay_pos + 16'd1;
                if (pay_pos >= frame_len) parse_ph = PH_CKA;
            end
            PH_CKA: begin
                if (c != run_sum_a) begin
                    ev = EV_CK;
                    parse_ph = PH_HUNT;
                end else begin
                    parse_ph = PH_CKB;
                end
            end
            PH_CKB: begin
                if (c != run_sum_b) begin
                    ev = EV_CK;
                end else begin
                    msg_held = 1'b1;
                    ev = EV_GOOD;
                end
                parse_ph = PH_HUNT;
            end
            default: begin
                parse_ph = PH_HUNT;
            end
        endcase
        return ev;
    endfunction

    function automatic t_result parse_request(logic [1:0] req, logic [7:0] data,
                                              logic [7:0] idx);
        t_result r;
        r = '0;
        case (req)
            REQ_RX: begin
                r.event_res = parse_byte(data);
            end
            REQ_REL: begin
                msg_held = 1'b0;
            end
            REQ_READ: begin
                if (idx < 8'(PAYLOAD_MAX)) r.read_data = pay_mem[idx];
            end
            default: begin
            end
        endcase
        r.msg_class = class_q;
        r.msg_id = id_q;
        r.msg_length = frame_len[7:0];
        r.msg_available = msg_held;
        r.overrun_count = drop_cnt;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("[%0t] %s mismatch: got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction event_res", 8'(o_event_res), 8'h00);
            end else begin
                want = pending_results.pop_front();
                check_field("event_res", 8'(o_event_res), 8'(want.event_res));
                check_field("msg_class", o_msg_class, want.msg_class);
                check_field("msg_id", o_msg_id, want.msg_id);
                check_field("msg_length", o_msg_length, want.msg_length);
                check_field("read_data", o_read_data, want.read_data);
                check_field("msg_available", 8'(o_msg_available),
                            8'(want.msg_available));
                check_field("overrun_count", o_overrun_count, want.overrun_count);
            end
        end
    end

    // output ready with random stalls and a single long hold-off
    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_left = 300;
            stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic send_item(logic [1:0] req, logic [7:0] data, logic [7:0] idx);
        int gap;
        gap = ($urandom_range(99) < in_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_rx_byte <= data;
        i_read_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(parse_request(req, data, idx));
        items_sent++;
    endtask

    task automatic rx_byte(logic [7:0] b);
        send_item(REQ_RX, b, 8'($urandom));
    endtask

    task automatic release_msg();
        send_item(REQ_REL, 8'($urandom), 8'($urandom));
    endtask

    task automatic read_buffer(logic [7:0] idx);
        send_item(REQ_READ, 8'($urandom), idx);
    endtask

    function automatic logic [7:0] pick_read_index();
        logic [7:0] idx;
        if (written_cnt == 0) return 8'hFF;
        do idx = 8'($urandom_range(0, PAYLOAD_MAX - 1)); while (!pay_written[idx]);
        return idx;
    endfunction

    function automatic logic [7:0] pick_filler_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == cfg_sync_first);
        return b;
    endfunction

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // bring the parser back to hunting before a clean frame
    task automatic resync();
        while (parse_ph != PH_HUNT) rx_byte(pick_filler_byte());
    endtask

    task automatic send_frame(t_frame_kind kind, logic [7:0] cls, logic [7:0] id, int len);
        logic [7:0]  bytes[$];
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [15:0] len16;
        int          keep;
        len16 = 16'(len);
        bytes = '{cfg_sync_first, cfg_sync_second, cls, id, len16[7:0], len16[15:8]};
        if (kind == FR_BAD_SYNC) bytes[1] = cfg_sync_second ^ 8'($urandom_range(1, 255));
        if (kind == FR_BAD_LEN || kind == FR_BAD_SYNC) begin
            if (kind == FR_BAD_SYNC) bytes = bytes[0:1];
        end else begin
            repeat (len) bytes.push_back(8'($urandom));
            ck_a = '0;
            ck_b = '0;
            for (int i = 2; i < bytes.size(); i++) begin
                ck_a = ck_a + bytes[i];
                ck_b = ck_b + ck_a;
            end
            if (kind == FR_BAD_CKA) ck_a = ck_a ^ 8'($urandom_range(1, 255));
            if (kind == FR_BAD_CKB) ck_b = ck_b ^ 8'($urandom_range(1, 255));
            bytes.push_back(ck_a);
            bytes.push_back(ck_b);
            if (kind == FR_CUT) begin
                keep = $urandom_range(1, bytes.size() - 1);
                bytes = bytes[0:keep-1];
            end
        end
        foreach (bytes[i]) rx_byte(bytes[i]);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h000000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SYNC_FIRST) begin
            cfg_sync_first = value;
        end else begin
            cfg_sync_second = value;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_sync(logic [7:0] first, logic [7:0] second);
        wait_drained();
        write_reg(REG_SYNC_FIRST, first);
        write_reg(REG_SYNC_SECOND, second);
    endtask

    task automatic test_special_cases();
        release_msg();
        read_buffer(8'hFF);
        send_item(REQ_SPARE, 8'hFF, 8'hFF);
        rx_byte(pick_filler_byte());
        send_frame(FR_BAD_SYNC, 8'h00, 8'h00, 0);
        send_frame(FR_GOOD, 8'hFF, 8'h00, 0);
        send_frame(FR_GOOD, 8'h00, 8'hFF, 1);
        release_msg();
        send_frame(FR_BAD_LEN, 8'h01, 8'h02, 256);
        send_frame(FR_BAD_LEN, 8'h03, 8'h04, 65535);
        send_frame(FR_BAD_CKA, 8'h05, 8'h06, 1);
        send_frame(FR_BAD_CKB, 8'h07, 8'h08, 0);
        send_frame(FR_GOOD, 8'h00, 8'hFF, 1);
        read_buffer(pick_read_index());
        release_msg();
        release_msg();
    endtask

    task automatic test_max_length();
        resync();
        send_frame(FR_GOOD, 8'hFF, 8'hFF, PAYLOAD_MAX);
        read_buffer(8'h00);
        read_buffer(8'h7F);
        read_buffer(8'h80);
        read_buffer(8'hFE);
        read_buffer(8'hFF);
        release_msg();
    endtask

    task automatic test_sync_config();
        set_sync(8'h00, 8'hFF);
        resync();
        send_frame(FR_GOOD, 8'h11, 8'h22, 2);
        release_msg();
        send_frame(FR_BAD_SYNC, 8'h00, 8'h00, 0);
        set_sync(8'hFF, 8'h00);
        resync();
        send_frame(FR_GOOD, 8'h33, 8'h44, 3);
        release_msg();
        send_frame(FR_BAD_SYNC, 8'h00, 8'h00, 0);
        set_sync(8'h5A, 8'h5A);
        resync();
        send_frame(FR_GOOD, 8'h55, 8'h66, 1);
        release_msg();
        set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
    endtask

    task automatic test_overrun_drop();
        resync();
        if (!msg_held) send_frame(FR_GOOD, 8'h01, 8'h01, 1);
        repeat (20) begin
            rx_byte(cfg_sync_first);
            rx_byte(cfg_sync_second);
            rx_byte(8'($urandom));
        end
        release_msg();
    endtask

    task automatic test_backpressure();
        wait_drained();
        in_idle_pct = 0;
        stall_req = 1'b1;
        resync();
        repeat (3) begin
            send_frame(FR_GOOD, 8'($urandom), 8'($urandom), 4);
            read_buffer(pick_read_index());
            release_msg();
        end
        wait_drained();
    endtask

    task automatic random_step();
        int pick;
        int len;
        pick = $urandom_range(99);
        len = ($urandom_range(99) < 3) ? $urandom_range(100, PAYLOAD_MAX)
                                       : $urandom_range(0, 12);
        if (pick < 45) begin
            resync();
            if (msg_held && $urandom_range(99) < 70) release_msg();
            send_frame(FR_GOOD, 8'($urandom), 8'($urandom), len);
        end else if (pick < 55) begin
            release_msg();
        end else if (pick < 65) begin
            read_buffer(pick_read_index());
        end else if (pick < 72) begin
            resync();
            send_frame($urandom_range(1) ? FR_BAD_CKA : FR_BAD_CKB,
                       8'($urandom), 8'($urandom), $urandom_range(0, 8));
        end else if (pick < 77) begin
            resync();
            send_frame(FR_BAD_SYNC, 8'h00, 8'h00, 0);
        end else if (pick < 81) begin
            resync();
            send_frame(FR_BAD_LEN, 8'($urandom), 8'($urandom),
                       $urandom_range(PAYLOAD_MAX + 1, 65535));
        end else if (pick < 86) begin
            resync();
            send_frame(FR_CUT, 8'($urandom), 8'($urandom), $urandom_range(0, 8));
        end else begin
            repeat ($urandom_range(1, 6)) rx_byte(8'($urandom));
        end
    endtask

    task automatic test_random(int in_pct, int out_pct, logic [7:0] first,
                               logic [7:0] second);
        int start;
        set_sync(first, second);
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        start = items_sent;
        while (items_sent - start < 75) random_step();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_max_length();
        test_sync_config();
        test_overrun_drop();
        test_backpressure();
        test_random(13, 54, 8'($urandom), 8'($urandom));
        test_random(54, 13, 8'($urandom), 8'($urandom));
        test_random(0, 0, SYNC_FIRST_RST, SYNC_SECOND_RST);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_ubx_frame_parser: PASS");
        end else begin
            $display("tb_ubx_frame_parser: FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_ubx_frame_parser: FAIL");
        $finish;
    end

endmodule
